FILE: rtl/swrt_pkg.sv
// ----------------------------------------------------------------------------
// swrt_pkg
// Shared constants, codes and types of the retransmit tracker.
// ----------------------------------------------------------------------------
package swrt_pkg;

    localparam int RING_DEPTH = 64;   // power of two
    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int CFG_ADDR_W = 3;

    localparam logic [0:0] REG_ARQ_MODE = 1'd0;
    localparam logic [0:0] REG_SEND_WIN = 1'd1;

    localparam logic [2:0] ACT_STORE     = 3'd0;
    localparam logic [2:0] ACT_UPDATE    = 3'd1;
    localparam logic [2:0] ACT_FRESH     = 3'd2;
    localparam logic [2:0] ACT_EXPIRED   = 3'd3;
    localparam logic [2:0] ACT_NEXT_DL   = 3'd4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_EOT  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_NO_ACTIVE = 2'd2;

    localparam logic       MODE_GBN = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  length;
        logic [31:0] deadline;
    } entry_t;

    typedef struct packed {
        logic             mode;
        logic [WIN_W-1:0] window;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] found_seq;
        logic [31:0] earliest;
        logic [15:0] base;
    } res_t;

    function automatic logic [WIN_W-1:0] eff_window(input logic [5:0] ws);
        int w;
        w = int'(ws);
        if (w < 1) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        if (w > RING_DEPTH) w = RING_DEPTH;
        return WIN_W'(w);
    endfunction

endpackage

FILE: rtl/sliding_window_retransmit_tracker.sv
// ----------------------------------------------------------------------------
// sliding_window_retransmit_tracker
// Sender-side send-window tracker for go-back-N or selective-repeat ARQ.
// ----------------------------------------------------------------------------
// Input channel (s_*): one item per action: store, update window, find
// fresh, find expired, next deadline. Result channel (m_*): one item per
// input item, in order.
// Store, out-of-range update, non-ACK update and unknown actions go from
// acceptance to the result with no scan. Scanning actions walk the full
// window (W = effective window size, 1..32); find scans stop early at the
// first hit, selective-repeat update at the first entry that is not an
// ACK, go-back-N update at the acked offset. The rate is set by the entry
// RAM read port: one entry is read per cycle, checked in the following one.
// One item is in work at a time. A finished result sits in an output
// register, so the next item is accepted while m_valid waits on m_ready;
// a result that finds the register still full holds until it drains.
// Reset clears all valid bits, the window base, arq_mode (go-back-N) and
// the window length (10) at once; no clearing pass is needed.
// Configuration is an APB port, arq_mode at 0x0, window length at 0x4.
// ----------------------------------------------------------------------------
module sliding_window_retransmit_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swrt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_action,
    input  logic [15:0]                     s_seq_num,
    input  logic [1:0]                      s_pkt_type,
    input  logic [8:0]                      s_payload_len,
    input  logic [31:0]                     s_deadline_in,
    input  logic [31:0]                     s_now_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic                            m_found,
    output logic [15:0]                     m_found_seq,
    output logic [31:0]                     m_earliest_deadline,
    output logic [15:0]                     m_window_base_out
);

    swrt_pkg::cfg_t   cfg;
    swrt_pkg::res_t   res;
    swrt_pkg::entry_t ram_wdata;
    swrt_pkg::entry_t ram_rdata;
    logic                        res_valid;
    logic                        res_ready;
    logic                        ram_we;
    logic [swrt_pkg::SLOT_W-1:0] ram_waddr;
    logic [swrt_pkg::SLOT_W-1:0] ram_raddr;

    swrt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swrt_ram #(
        .WIDTH ($bits(swrt_pkg::entry_t)),
        .DEPTH (swrt_pkg::RING_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swrt_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_seq_num     (s_seq_num),
        .s_pkt_type    (s_pkt_type),
        .s_payload_len (s_payload_len),
        .s_deadline_in (s_deadline_in),
        .s_now_time    (s_now_time),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .res           (res),
        .res_valid     (res_valid),
        .res_ready     (res_ready)
    );

    swrt_out u_out (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .res                 (res),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_found             (m_found),
        .m_found_seq         (m_found_seq),
        .m_earliest_deadline (m_earliest_deadline),
        .m_window_base_out   (m_window_base_out)
    );

endmodule

FILE: rtl/swrt_ram.sv
// ----------------------------------------------------------------------------
// swrt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/swrt_cfg.sv
// ----------------------------------------------------------------------------
// swrt_cfg
// APB register file: ARQ mode and window size.
// ----------------------------------------------------------------------------
module swrt_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swrt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output swrt_pkg::cfg_t                  cfg
);

    logic       mode_reg;
    logic [5:0] window_reg;
    logic [0:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[swrt_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            window_reg <= 6'd10;
        end else if (wr_en) begin
            case (reg_idx)
                swrt_pkg::REG_ARQ_MODE: mode_reg   <= pwdata[0];
                swrt_pkg::REG_SEND_WIN: window_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            swrt_pkg::REG_ARQ_MODE: prdata = {31'd0, mode_reg};
            swrt_pkg::REG_SEND_WIN: prdata = {26'd0, window_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.mode   = mode_reg;
    assign cfg.window = swrt_pkg::eff_window(window_reg);

endmodule

FILE: rtl/swrt_engine.sv
// ----------------------------------------------------------------------------
// swrt_engine
// Action sequencer: entry valid bits, window base, and the per-entry scan
// over the entry RAM (one read issued per cycle, checked the next).
// ----------------------------------------------------------------------------
module swrt_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swrt_pkg::cfg_t              cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_action,
    input  logic [15:0]                 s_seq_num,
    input  logic [1:0]                  s_pkt_type,
    input  logic [8:0]                  s_payload_len,
    input  logic [31:0]                 s_deadline_in,
    input  logic [31:0]                 s_now_time,
    output logic                        ram_we,
    output logic [swrt_pkg::SLOT_W-1:0] ram_waddr,
    output swrt_pkg::entry_t            ram_wdata,
    output logic [swrt_pkg::SLOT_W-1:0] ram_raddr,
    input  swrt_pkg::entry_t            ram_rdata,
    output swrt_pkg::res_t              res,
    output logic                        res_valid,
    input  logic                        res_ready
);

    localparam int SW = swrt_pkg::SLOT_W;
    localparam int WW = swrt_pkg::WIN_W;
    localparam logic [15:0] RING_LIMIT = 16'(swrt_pkg::RING_DEPTH);

    swrt_pkg::fsm_state_t state_reg, state_next;

    logic [swrt_pkg::RING_DEPTH-1:0] valid_reg;
    logic [15:0]   base_reg;
    logic [WW-1:0] idx_reg;
    logic [2:0]    act_reg;
    logic [15:0]   seq_reg;
    logic [15:0]   off_reg;
    logic [1:0]    kind_reg;
    logic [8:0]    len_reg;
    logic [31:0]   dl_reg;
    logic [31:0]   now_reg;
    logic [1:0]    status_reg;
    logic          found_reg;
    logic [15:0]   fseq_reg;
    logic [31:0]   early_reg;

    logic [SW-1:0] base_slot;
    logic [SW-1:0] chk_slot;
    logic          chk_valid;
    logic [WW-1:0] idx_inc;
    logic          idx_last;
    logic          store_ok;
    logic          upd_in_range;
    logic          need_scan;
    logic          is_ack;
    logic          hit;
    logic          hit_dl;
    logic          scan_stop;
    logic          clear_en;
    logic [15:0]   base_next;
    logic [15:0]   cur_seq;

    assign base_slot    = base_reg[SW-1:0];
    assign chk_slot     = base_slot + SW'(idx_reg);
    assign chk_valid    = valid_reg[chk_slot];
    assign idx_inc      = idx_reg + 1'b1;
    assign idx_last     = (idx_inc == cfg.window);
    assign cur_seq      = base_reg + 16'(idx_reg);
    assign store_ok     = off_reg < RING_LIMIT;
    assign upd_in_range = off_reg < 16'(cfg.window);
    assign is_ack       = chk_valid && (ram_rdata.kind == swrt_pkg::KIND_ACK);

    always_comb begin
        case (act_reg)
            swrt_pkg::ACT_UPDATE:
                need_scan = upd_in_range && (kind_reg == swrt_pkg::KIND_ACK);
            swrt_pkg::ACT_FRESH, swrt_pkg::ACT_EXPIRED, swrt_pkg::ACT_NEXT_DL:
                need_scan = 1'b1;
            default:
                need_scan = 1'b0;
        endcase
    end

    always_comb begin
        hit       = 1'b0;
        hit_dl    = 1'b0;
        scan_stop = 1'b0;
        clear_en  = 1'b0;
        base_next = base_reg;
        case (act_reg)
            swrt_pkg::ACT_UPDATE: begin
                if (cfg.mode == swrt_pkg::MODE_GBN) begin
                    clear_en  = 1'b1;
                    scan_stop = (idx_reg == off_reg[WW-1:0]);
                    base_next = base_reg + off_reg + 16'd1;
                end else begin
                    clear_en  = is_ack;
                    scan_stop = !is_ack || idx_last;
                    base_next = is_ack ? base_reg + 16'(idx_inc)
                                       : base_reg + 16'(idx_reg);
                end
            end
            swrt_pkg::ACT_FRESH: begin
                hit = chk_valid && (ram_rdata.kind == swrt_pkg::KIND_DATA) &&
                      (ram_rdata.length != 9'd0) && (ram_rdata.deadline == 32'd0);
                scan_stop = hit || idx_last;
            end
            swrt_pkg::ACT_EXPIRED: begin
                hit = chk_valid && (ram_rdata.deadline != 32'd0) &&
                      (ram_rdata.deadline <= now_reg);
                scan_stop = hit || idx_last;
            end
            swrt_pkg::ACT_NEXT_DL: begin
                hit_dl = chk_valid &&
                         ((ram_rdata.kind == swrt_pkg::KIND_DATA) ||
                          (ram_rdata.kind == swrt_pkg::KIND_EOT)) &&
                         (ram_rdata.deadline != 32'd0) &&
                         (!found_reg || (ram_rdata.deadline < early_reg));
                scan_stop = idx_last;
            end
            default: scan_stop = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swrt_pkg::ST_IDLE:   if (s_valid) state_next = swrt_pkg::ST_EXEC;
            swrt_pkg::ST_EXEC:   state_next = need_scan ? swrt_pkg::ST_SCAN
                                                        : swrt_pkg::ST_RESULT;
            swrt_pkg::ST_SCAN:   if (scan_stop) state_next = swrt_pkg::ST_RESULT;
            swrt_pkg::ST_RESULT: if (res_ready) state_next = swrt_pkg::ST_IDLE;
            default:             state_next = swrt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = (state_reg == swrt_pkg::ST_IDLE);
        res_valid = (state_reg == swrt_pkg::ST_RESULT);
        ram_we    = (state_reg == swrt_pkg::ST_EXEC) &&
                    (act_reg == swrt_pkg::ACT_STORE) && store_ok;
        ram_waddr = seq_reg[SW-1:0];
        ram_wdata.kind     = kind_reg;
        ram_wdata.length   = len_reg;
        ram_wdata.deadline = dl_reg;
        ram_raddr = (state_reg == swrt_pkg::ST_SCAN) ? chk_slot + 1'b1 : base_slot;
        res.status    = status_reg;
        res.found     = found_reg;
        res.found_seq = fseq_reg;
        res.earliest  = early_reg;
        res.base      = base_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swrt_pkg::ST_IDLE;
            valid_reg <= '0;
            base_reg  <= 16'd0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                valid_reg[seq_reg[SW-1:0]] <= 1'b1;
            end
            if (state_reg == swrt_pkg::ST_SCAN && act_reg == swrt_pkg::ACT_UPDATE &&
                clear_en) begin
                valid_reg[chk_slot] <= 1'b0;
            end
            if (state_reg == swrt_pkg::ST_SCAN && act_reg == swrt_pkg::ACT_UPDATE &&
                scan_stop) begin
                base_reg <= base_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            swrt_pkg::ST_IDLE: begin
                act_reg    <= s_action;
                seq_reg    <= s_seq_num;
                off_reg    <= s_seq_num - base_reg;
                kind_reg   <= s_pkt_type;
                len_reg    <= s_payload_len;
                dl_reg     <= s_deadline_in;
                now_reg    <= s_now_time;
                idx_reg    <= '0;
                status_reg <= swrt_pkg::STAT_OK;
                found_reg  <= 1'b0;
                fseq_reg   <= 16'd0;
                early_reg  <= 32'd0;
            end
            swrt_pkg::ST_EXEC: begin
                if ((act_reg == swrt_pkg::ACT_STORE && !store_ok) ||
                    (act_reg == swrt_pkg::ACT_UPDATE && !upd_in_range)) begin
                    status_reg <= swrt_pkg::STAT_RANGE;
                end
            end
            swrt_pkg::ST_SCAN: begin
                idx_reg <= idx_inc;
                if (hit) begin
                    found_reg <= 1'b1;
                    fseq_reg  <= cur_seq;
                end
                if (hit_dl) begin
                    found_reg <= 1'b1;
                    fseq_reg  <= cur_seq;
                    early_reg <= ram_rdata.deadline;
                end
                if (act_reg == swrt_pkg::ACT_NEXT_DL && scan_stop &&
                    !found_reg && !hit_dl) begin
                    status_reg <= swrt_pkg::STAT_NO_ACTIVE;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/swrt_out.sv
// ----------------------------------------------------------------------------
// swrt_out
// Output register of the result channel.
// ----------------------------------------------------------------------------
module swrt_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  swrt_pkg::res_t res,
    input  logic           res_valid,
    output logic           res_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic           m_found,
    output logic [15:0]    m_found_seq,
    output logic [31:0]    m_earliest_deadline,
    output logic [15:0]    m_window_base_out
);

    logic           valid_reg;
    swrt_pkg::res_t data_reg;

    assign res_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid             = valid_reg;
    assign m_status            = data_reg.status;
    assign m_found             = data_reg.found;
    assign m_found_seq         = data_reg.found_seq;
    assign m_earliest_deadline = data_reg.earliest;
    assign m_window_base_out   = data_reg.base;

endmodule

FILE: bench/tb_sliding_window_retransmit_tracker.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_retransmit_tracker
// Self-checking bench for the send-window retransmit tracker. A queue of
// pending items feeds a bursty valid/ready driver; each accepted item runs
// through a local copy of the window state and its result is queued. A
// monitor compares every result with the oldest queued one, field by field.
// Directed items cover range errors, both ARQ modes and every search; random
// phases then sweep arq_mode and the window length, including the saturating
// ends, under several receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_sliding_window_retransmit_tracker;
    import swrt_pkg::*;

    localparam int       WATCHDOG_LIMIT = 5000;
    localparam int       PHASE_ITEMS    = 70;
    localparam logic     MODE_SR        = 1'b1;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_SPARSE} ready_style_t;

    typedef struct {
        logic [2:0]  action;
        logic [15:0] seq;
        logic [1:0]  kind;
        logic [8:0]  len;
        logic [31:0] dl;
        logic [31:0] now;
        bit          rel;    // seq is an offset from the base at drive time
    } act_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_action      = '0;
    logic [15:0]           s_seq_num     = '0;
    logic [1:0]            s_pkt_type    = '0;
    logic [8:0]            s_payload_len = '0;
    logic [31:0]           s_deadline_in = '0;
    logic [31:0]           s_now_time    = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [1:0]            m_status;
    logic                  m_found;
    logic [15:0]           m_found_seq;
    logic [31:0]           m_earliest_deadline;
    logic [15:0]           m_window_base_out;

    sliding_window_retransmit_tracker dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_seq_num           (s_seq_num),
        .s_pkt_type          (s_pkt_type),
        .s_payload_len       (s_payload_len),
        .s_deadline_in       (s_deadline_in),
        .s_now_time          (s_now_time),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_found             (m_found),
        .m_found_seq         (m_found_seq),
        .m_earliest_deadline (m_earliest_deadline),
        .m_window_base_out   (m_window_base_out)
    );

    always #10 aclk = ~aclk;

    // window state as the block should hold it
    bit          ent_valid [RING_DEPTH];
    logic [1:0]  ent_kind  [RING_DEPTH];
    logic [8:0]  ent_len   [RING_DEPTH];
    logic [31:0] ent_dl    [RING_DEPTH];
    logic [15:0] win_base  = '0;
    int          base_slot = 0;
    logic        cfg_mode_m = MODE_GBN;
    logic [5:0]  cfg_win_m  = 6'd10;

    act_t         action_q [$];
    res_t         action_results [$];
    act_t         drive_item;
    act_t         seen;
    res_t         want;
    res_t         got;
    int           errors       = 0;
    int           items_in     = 0;
    int           results_out  = 0;
    int           search_hits  = 0;
    int           settings_run = 0;
    int           idle_cycles  = 0;
    int           burst_left   = 1;
    int           gap_left     = 0;
    int           ready_tick   = 0;
    bit           item_taken   = 1'b0;
    bit           sender_eager = 1'b0;
    ready_style_t ready_style  = RDY_ALWAYS;

    task automatic run_action(input act_t a, output res_t r);
        logic [15:0] off16;
        int          off, w, n, i, s;
        bit          hit;
        r     = '0;
        off16 = a.seq - win_base;
        off   = int'(off16);
        w     = int'(cfg_win_m);
        if (w < 1) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        if (w > RING_DEPTH) w = RING_DEPTH;
        case (a.action)
            ACT_STORE: begin
                if (off >= RING_DEPTH) begin
                    r.status = STAT_RANGE;
                end else begin
                    s            = (base_slot + off) % RING_DEPTH;
                    ent_valid[s] = 1'b1;
                    ent_kind[s]  = a.kind;
                    ent_len[s]   = a.len;
                    ent_dl[s]    = a.dl;
                end
            end
            ACT_UPDATE: begin
                if (off >= w) begin
                    r.status = STAT_RANGE;
                end else if (a.kind == KIND_ACK) begin
                    if (cfg_mode_m == MODE_GBN) begin
                        n = off + 1;
                    end else begin
                        n = 0;
                        while (n < w) begin
                            s = (base_slot + n) % RING_DEPTH;
                            if (!ent_valid[s] || ent_kind[s] != KIND_ACK) break;
                            n++;
                        end
                    end
                    for (i = 0; i < n; i++) begin
                        ent_valid[base_slot] = 1'b0;
                        base_slot = (base_slot + 1) % RING_DEPTH;
                    end
                    win_base = win_base + 16'(n);
                end
            end
            ACT_FRESH, ACT_EXPIRED: begin
                for (i = 0; i < w && !r.found; i++) begin
                    s = (base_slot + i) % RING_DEPTH;
                    if (ent_valid[s]) begin
                        if (a.action == ACT_FRESH)
                            hit = ent_kind[s] == KIND_DATA && ent_len[s] != 0 && ent_dl[s] == 0;
                        else
                            hit = ent_dl[s] != 0 && ent_dl[s] <= a.now;
                        if (hit) begin
                            r.found     = 1'b1;
                            r.found_seq = win_base + 16'(i);
                        end
                    end
                end
            end
            ACT_NEXT_DL: begin
                for (i = 0; i < w; i++) begin
                    s = (base_slot + i) % RING_DEPTH;
                    if (ent_valid[s] && (ent_kind[s] == KIND_DATA || ent_kind[s] == KIND_EOT) &&
                        ent_dl[s] != 0 && (!r.found || ent_dl[s] < r.earliest)) begin
                        r.found     = 1'b1;
                        r.earliest  = ent_dl[s];
                        r.found_seq = win_base + 16'(i);
                    end
                end
                if (!r.found) r.status = STAT_NO_ACTIVE;
            end
            default: ;
        endcase
        r.base = win_base;
    endtask

    function automatic act_t mk(input logic [2:0] ac, input logic [15:0] sq, input logic [1:0] k,
                                input logic [8:0] ln, input logic [31:0] d, input logic [31:0] nw,
                                input bit rel);
        act_t a;
        a.action = ac;
        a.seq    = sq;
        a.kind   = k;
        a.len    = ln;
        a.dl     = d;
        a.now    = nw;
        a.rel    = rel;
        return a;
    endfunction

    function automatic logic [31:0] pick_deadline();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 32'd0;
        if (r < 85) return 32'($urandom_range(1, 1000));
        if (r < 95) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'd0;
        if (r < 80) return 32'($urandom_range(0, 1100));
        if (r < 95) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [1:0] pick_kind(input bit ack_heavy);
        if (ack_heavy && $urandom_range(0, 99) < 60) return KIND_ACK;
        case ($urandom_range(0, 2))
            0:       return KIND_DATA;
            1:       return KIND_ACK;
            default: return KIND_EOT;
        endcase
    endfunction

    function automatic logic [8:0] pick_len();
        if ($urandom_range(0, 3) == 0) return 9'd0;
        return 9'($urandom_range(1, 500));
    endfunction

    task automatic queue_random_items(input int count);
        int  made, pick, off, wl, j, runlen;
        bit  sr;
        made = 0;
        sr   = cfg_mode_m == MODE_SR;
        wl   = (cfg_win_m == 0) ? 1 : ((cfg_win_m > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_win_m));
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 36) begin
                j = $urandom_range(0, 99);
                off = (j < 80) ? $urandom_range(0, wl + 1) :
                      (j < 92) ? $urandom_range(0, RING_DEPTH - 1) :
                                 $urandom_range(RING_DEPTH, RING_DEPTH + 16);
                action_q.push_back(mk(ACT_STORE, 16'(off), pick_kind(sr), pick_len(),
                                      pick_deadline(), pick_now(), 1'b1));
                made++;
            end else if (pick < 54) begin
                off = ($urandom_range(0, 99) < 85) ? $urandom_range(0, wl - 1) :
                                                     $urandom_range(wl, wl + 4);
                action_q.push_back(mk(ACT_UPDATE, 16'(off),
                                      ($urandom_range(0, 3) != 0) ? KIND_ACK : pick_kind(1'b0),
                                      pick_len(), pick_deadline(), pick_now(), 1'b1));
                made++;
            end else if (pick < 62) begin
                // run of acknowledged entries from the base, then an ack
                runlen = $urandom_range(1, wl);
                for (j = 0; j < runlen; j++)
                    action_q.push_back(mk(ACT_STORE, 16'(j), KIND_ACK, pick_len(),
                                          pick_deadline(), pick_now(), 1'b1));
                action_q.push_back(mk(ACT_UPDATE, 16'($urandom_range(0, wl - 1)), KIND_ACK,
                                      pick_len(), pick_deadline(), pick_now(), 1'b1));
                made += runlen + 1;
            end else if (pick < 71) begin
                action_q.push_back(mk(ACT_FRESH, 16'($urandom), pick_kind(1'b0), pick_len(),
                                      $urandom, pick_now(), 1'b0));
                made++;
            end else if (pick < 80) begin
                action_q.push_back(mk(ACT_EXPIRED, 16'($urandom), pick_kind(1'b0), pick_len(),
                                      $urandom, pick_now(), 1'b0));
                made++;
            end else if (pick < 89) begin
                action_q.push_back(mk(ACT_NEXT_DL, 16'($urandom), pick_kind(1'b0), pick_len(),
                                      $urandom, pick_now(), 1'b0));
                made++;
            end else if (pick < 92) begin
                action_q.push_back(mk(ACT_NEXT_DL + 3'($urandom_range(1, 3)), 16'($urandom),
                                      pick_kind(1'b0), pick_len(), $urandom, $urandom, 1'b0));
                made++;
            end else begin
                // noise: anything, absolute sequence number
                action_q.push_back(mk(3'($urandom_range(0, 7)), 16'($urandom), pick_kind(1'b0),
                                      pick_len(), $urandom, $urandom, 1'b0));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (action_q.size() != 0 || s_valid || action_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic mode, input logic [5:0] win, input int count,
                             input ready_style_t style, input bit eager);
        wait_drained();
        cfg_write({REG_ARQ_MODE, 2'b00}, ($urandom & ~32'h1) | 32'(mode));
        cfg_write({REG_SEND_WIN, 2'b00}, ($urandom & ~32'h3F) | 32'(win));
        cfg_mode_m   = mode;
        cfg_win_m    = win;
        ready_style  = style;
        sender_eager = eager;
        settings_run++;
        queue_random_items(count);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (action_q.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                drive_item     = action_q.pop_front();
                s_action      <= drive_item.action;
                s_seq_num     <= drive_item.rel ? win_base + drive_item.seq : drive_item.seq;
                s_pkt_type    <= drive_item.kind;
                s_payload_len <= drive_item.len;
                s_deadline_in <= drive_item.dl;
                s_now_time    <= drive_item.now;
                s_valid       <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = sender_eager ? 0 : $urandom_range(0, 10);
                end
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            ready_tick++;
            case (ready_style)
                RDY_ALWAYS:   m_ready <= 1'b1;
                RDY_RANDOM:   m_ready <= $urandom_range(0, 99) < 60;
                RDY_PERIODIC: m_ready <= (ready_tick % 9) < 5;
                default:      m_ready <= $urandom_range(0, 5) == 0;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: predicts on input acceptance, checks on result acceptance
    always @(posedge aclk) begin
        item_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.action = s_action;
                seen.seq    = s_seq_num;
                seen.kind   = s_pkt_type;
                seen.len    = s_payload_len;
                seen.dl     = s_deadline_in;
                seen.now    = s_now_time;
                seen.rel    = 1'b0;
                run_action(seen, want);
                action_results.push_back(want);
                items_in++;
                if (want.found) search_hits++;
            end
            if (m_valid && m_ready) begin
                results_out++;
                if (action_results.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0h base %0h",
                             $time, m_status, m_window_base_out);
                    errors++;
                end else begin
                    got = action_results.pop_front();
                    check_field("status", 32'(got.status), 32'(m_status));
                    check_field("found", 32'(got.found), 32'(m_found));
                    check_field("found_seq", 32'(got.found_seq), 32'(m_found_seq));
                    check_field("earliest_deadline", got.earliest, m_earliest_deadline);
                    check_field("window_base_out", 32'(got.base), 32'(m_window_base_out));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        ready_style  = RDY_RANDOM;
        sender_eager = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // go-back-N, reset window of 10
        action_q.push_back(mk(ACT_STORE, 16'd0, KIND_DATA, 9'd500, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd1, KIND_DATA, 9'd1, 32'd100, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd2, KIND_EOT, 9'd0, 32'd50, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd63, KIND_ACK, 9'd0, 32'hFFFF_FFFF, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd64, KIND_DATA, 9'd4, 32'd9, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'hFFFF, KIND_DATA, 9'd4, 32'd9, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_FRESH, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_EXPIRED, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd49, 1'b0));
        action_q.push_back(mk(ACT_EXPIRED, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd50, 1'b0));
        action_q.push_back(mk(ACT_NEXT_DL, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_UPDATE, 16'd10, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_UPDATE, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_UPDATE, 16'd1, KIND_EOT, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_UPDATE, 16'd1, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_FRESH, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_UPDATE, 16'd0, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_NEXT_DL, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_STORE, 16'd9, KIND_DATA, 9'd3, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_FRESH, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_STORE, 16'd0, KIND_EOT, 9'd0, 32'd1, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_EXPIRED, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'd0, 1'b0));
        action_q.push_back(mk(ACT_EXPIRED, 16'd0, KIND_DATA, 9'd0, 32'd0, 32'hFFFF_FFFF, 1'b0));
        action_q.push_back(mk(ACT_NEXT_DL + 3'd1, 16'($urandom), KIND_ACK, 9'd7,
                              $urandom, $urandom, 1'b0));
        action_q.push_back(mk(ACT_NEXT_DL + 3'd2, 16'($urandom), KIND_EOT, 9'd7,
                              $urandom, $urandom, 1'b0));
        action_q.push_back(mk(ACT_NEXT_DL + 3'd3, 16'($urandom), KIND_DATA, 9'd7,
                              $urandom, $urandom, 1'b0));
        queue_random_items(40);
        settings_run++;

        // selective repeat, full window
        run_phase(MODE_SR, 6'd32, 0, RDY_ALWAYS, 1'b1);
        action_q.push_back(mk(ACT_STORE, 16'd1, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd0, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd2, KIND_DATA, 9'd7, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_UPDATE, 16'd0, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_STORE, 16'd31, KIND_ACK, 9'd0, 32'd5, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_UPDATE, 16'd31, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        action_q.push_back(mk(ACT_UPDATE, 16'd32, KIND_ACK, 9'd0, 32'd0, 32'd0, 1'b1));
        queue_random_items(PHASE_ITEMS);

        run_phase(MODE_GBN, 6'd1, PHASE_ITEMS, RDY_PERIODIC, 1'b0);
        run_phase(MODE_SR, 6'd0, PHASE_ITEMS, RDY_SPARSE, 1'b0);
        run_phase(MODE_GBN, 6'd63, PHASE_ITEMS, RDY_RANDOM, 1'b1);
        run_phase(MODE_SR, 6'd5, PHASE_ITEMS, RDY_PERIODIC, 1'b0);
        run_phase(MODE_GBN, 6'd33, PHASE_ITEMS, RDY_ALWAYS, 1'b0);
        run_phase(MODE_SR, 6'd17, PHASE_ITEMS, RDY_RANDOM, 1'b0);
        run_phase(MODE_GBN, 6'd10, PHASE_ITEMS, RDY_SPARSE, 1'b1);
        run_phase(MODE_SR, 6'd32, PHASE_ITEMS, RDY_RANDOM, 1'b0);
        wait_drained();
        repeat (60) @(posedge aclk);

        $display("Run covered %0d items and %0d results over %0d register settings,",
                 items_in, results_out, settings_run);
        $display("both ARQ modes, windows 1 to 32, %0d search hits, final base %0h",
                 search_hits, win_base);
        if (errors == 0 && action_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, action_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/swrt_pkg.sv
rtl/swrt_ram.sv
rtl/swrt_cfg.sv
rtl/swrt_engine.sv
rtl/swrt_out.sv
rtl/sliding_window_retransmit_tracker.sv
bench/tb_sliding_window_retransmit_tracker.sv
